// ----- rtl/core/d2q9mc_pkg.sv -----
// shared types, widths and helpers for the d2q9 moment calculator
// no dependencies
package d2q9mc_pkg;

	localparam int POP_W   = 32;
	localparam int MAG_W   = 36;
	localparam int Q_W     = 32;
	localparam int CFG_W   = 31;
	localparam int SAT_W   = 37;
	localparam int N_LANE  = 5;

	// lane order
	localparam int LANE_X  = 0;
	localparam int LANE_Y  = 1;
	localparam int LANE_XX = 2;
	localparam int LANE_YY = 3;
	localparam int LANE_XY = 4;

	// register indexes
	localparam logic REG_SOUND_SPEED_SQ    = 1'b0;
	localparam logic REG_REFERENCE_DENSITY = 1'b1;

	localparam logic [CFG_W-1:0] SOUND_SPEED_SQ_RST    = 31'd89478485;
	localparam logic [CFG_W-1:0] REFERENCE_DENSITY_RST = 31'd268435456;

	typedef logic signed [MAG_W-1:0] wide_t;
	typedef logic [Q_W-1:0] word_t;

	// saturate a wide signed value to the 32 bit field range
	function automatic word_t sat32(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-Q_W:0] top;
		begin
			top = v[SAT_W-1:Q_W-1];
			if (top == '0 || top == '1)
				sat32 = v[Q_W-1:0];
			else if (v[SAT_W-1])
				sat32 = {1'b1, {(Q_W-1){1'b0}}};
			else
				sat32 = {1'b0, {(Q_W-1){1'b1}}};
		end
	endfunction

endpackage

// ----- rtl/core/d2q9mc_sums.sv -----
// population sums: density and the five weighted moment sums
// depends on d2q9mc_pkg
module d2q9mc_sums import d2q9mc_pkg::*; (
	input  logic [POP_W-1:0] pops [9],
	output wide_t            rho,
	output wide_t            nums [N_LANE]
);

	wide_t p [9];

	// sign extend every population
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			p[i] = wide_t'(signed'(pops[i]));
		end
	end

	// exact sums, no wrap at this width
	always_comb begin
		rho = ((p[0] + p[1]) + (p[2] + p[3])) + ((p[4] + p[5]) + (p[6] + p[7])) + p[8];
		nums[LANE_X]  = (p[1] - p[3]) + (p[5] - p[6]) + (p[8] - p[7]);
		nums[LANE_Y]  = (p[2] - p[4]) + (p[5] + p[6]) - (p[7] + p[8]);
		nums[LANE_XX] = (p[1] + p[3]) + (p[5] + p[6]) + (p[7] + p[8]);
		nums[LANE_YY] = (p[2] + p[4]) + (p[5] + p[6]) + (p[7] + p[8]);
		nums[LANE_XY] = (p[5] - p[6]) + (p[7] - p[8]);
	end

endmodule

// ----- rtl/core/d2q9mc_div_step.sv -----
// one restoring division step: one quotient bit
// depends on d2q9mc_pkg
module d2q9mc_div_step import d2q9mc_pkg::*; (
	input  logic [MAG_W-1:0] rem_in,
	input  word_t            nq_in,
	input  logic [MAG_W-1:0] divisor,
	output logic [MAG_W-1:0] rem_out,
	output word_t            nq_out
);

	logic [MAG_W:0] shifted;
	logic [MAG_W:0] diff;
	logic           ge;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		shifted = {rem_in, nq_in[Q_W-1]};
		diff    = shifted - {1'b0, divisor};
		ge      = shifted >= {1'b0, divisor};
		rem_out = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
		nq_out  = {nq_in[Q_W-2:0], ge};
	end

endmodule

// ----- rtl/core/d2q9mc_post.sv -----
// sign, saturation and sound speed offset of one quotient lane
// depends on d2q9mc_pkg
module d2q9mc_post import d2q9mc_pkg::*; (
	input  word_t            quot,
	input  logic             neg,
	input  logic             ovf,
	input  logic             sub_cs,
	input  logic [CFG_W-1:0] cs,
	input  logic             bad,
	output word_t            result
);

	word_t                   qs;
	logic signed [SAT_W-1:0] diff;

	always_comb begin
		// saturate the signed quotient
		if (ovf || quot[Q_W-1])
			qs = neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		else
			qs = neg ? (~quot + 1'b1) : quot;
		// optional offset, saturated again
		diff = {{(SAT_W-Q_W){qs[Q_W-1]}}, qs} - {{(SAT_W-CFG_W){1'b0}}, cs};
		if (bad)
			result = '0;
		else if (sub_cs)
			result = sat32(diff);
		else
			result = qs;
	end

endmodule

// ----- rtl/core/d2q9_moment_calc_top.sv -----
// d2q9 moment calculator top level: sums, divider pipeline, output stage
// depends on d2q9mc_pkg, d2q9mc_sums, d2q9mc_div_step, d2q9mc_post
// pipeline: a sum stage, a prep stage, one divide stage per quotient bit, an output stage
// throughput: one item per cycle while the output is not stalled; the divider takes one quotient bit per stage
// stall: every stage holds while the one after is full and held; bubbles are squeezed out
// reset: arst_n clears all valid bits and loads the register defaults
module d2q9_moment_calc_top import d2q9mc_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [POP_W-1:0] pop_rest,
	input  logic [POP_W-1:0] pop_east,
	input  logic [POP_W-1:0] pop_north,
	input  logic [POP_W-1:0] pop_west,
	input  logic [POP_W-1:0] pop_south,
	input  logic [POP_W-1:0] pop_northeast,
	input  logic [POP_W-1:0] pop_northwest,
	input  logic [POP_W-1:0] pop_southwest,
	input  logic [POP_W-1:0] pop_southeast,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [Q_W-1:0]   rho_deviation,
	output logic [Q_W-1:0]   velocity_x,
	output logic [Q_W-1:0]   velocity_y,
	output logic [Q_W-1:0]   moment_xx,
	output logic [Q_W-1:0]   moment_yy,
	output logic [Q_W-1:0]   moment_xy,
	output logic             bad_density
);

	localparam int NW     = MAG_W + FRAC_BITS;
	localparam int N_DIV  = Q_W;
	localparam int N_STG  = N_DIV + 3;
	localparam int DIV0   = 2;

	// configuration registers
	logic [CFG_W-1:0] sound_speed_sq_q;
	logic [CFG_W-1:0] reference_density_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_speed_sq_q    <= SOUND_SPEED_SQ_RST;
			reference_density_q <= REFERENCE_DENSITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOUND_SPEED_SQ:    sound_speed_sq_q    <= cfg_data;
				REG_REFERENCE_DENSITY: reference_density_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control: a stage loads when empty or when its item moves on
	logic [N_STG-1:0] vld_q;
	logic [N_STG-1:0] ld;

	always_comb begin
		ld[N_STG-1] = !vld_q[N_STG-1] || !out_stall;
		for (int i = N_STG-2; i >= 0; i--) begin
			ld[i] = !vld_q[i] || ld[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < N_STG; i++) begin
				if (ld[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign in_stall  = !ld[0];
	assign out_valid = vld_q[N_STG-1];

	// stage 1: sums
	logic [POP_W-1:0] pops [9];
	wide_t            rho_c;
	wide_t            nums_c [N_LANE];
	wide_t            rho_s1;
	wide_t            nums_s1 [N_LANE];

	always_comb begin
		pops[0] = pop_rest;
		pops[1] = pop_east;
		pops[2] = pop_north;
		pops[3] = pop_west;
		pops[4] = pop_south;
		pops[5] = pop_northeast;
		pops[6] = pop_northwest;
		pops[7] = pop_southwest;
		pops[8] = pop_southeast;
	end

	d2q9mc_sums u_sums (
		.pops (pops),
		.rho  (rho_c),
		.nums (nums_c)
	);

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			rho_s1  <= rho_c;
			nums_s1 <= nums_c;
		end
	end

	// stage 2: density checks, magnitudes, first partial remainder
	logic                   bad_c;
	logic signed [SAT_W-1:0] dev_c;
	logic [MAG_W-1:0]       mag_c [N_LANE];
	logic [NW-1:0]          nfull_c [N_LANE];
	logic [NW-1:0]          hi_c [N_LANE];

	logic                   bad_s2;
	word_t                  dev_s2;
	logic [MAG_W-1:0]       den_s2;
	logic [N_LANE-1:0]      neg_s2;
	logic [N_LANE-1:0]      ovf_s2;
	logic [MAG_W-1:0]       rem_s2 [N_LANE];
	word_t                  nq_s2 [N_LANE];

	always_comb begin
		bad_c = rho_s1[MAG_W-1] || (rho_s1 == '0);
		dev_c = {rho_s1[MAG_W-1], rho_s1} - {{(SAT_W-CFG_W){1'b0}}, reference_density_q};
		for (int l = 0; l < N_LANE; l++) begin
			mag_c[l]   = nums_s1[l][MAG_W-1] ? (~nums_s1[l] + 1'b1) : nums_s1[l];
			nfull_c[l] = {mag_c[l], {FRAC_BITS{1'b0}}};
			hi_c[l]    = nfull_c[l] >> Q_W;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			bad_s2 <= bad_c;
			dev_s2 <= sat32(dev_c);
			den_s2 <= rho_s1;
			for (int l = 0; l < N_LANE; l++) begin
				neg_s2[l] <= nums_s1[l][MAG_W-1];
				ovf_s2[l] <= hi_c[l] >= {{(NW-MAG_W){1'b0}}, rho_s1};
				rem_s2[l] <= hi_c[l][MAG_W-1:0];
				nq_s2[l]  <= nfull_c[l][Q_W-1:0];
			end
		end
	end

	// divide stages: one quotient bit per stage in every lane
	logic              div_bad_s   [N_DIV+1];
	word_t             div_dev_s   [N_DIV+1];
	logic [MAG_W-1:0]  div_den_s   [N_DIV+1];
	logic [N_LANE-1:0] div_neg_s   [N_DIV+1];
	logic [N_LANE-1:0] div_ovf_s   [N_DIV+1];
	logic [MAG_W-1:0]  div_rem_s   [N_DIV+1][N_LANE];
	word_t             div_nq_s    [N_DIV+1][N_LANE];

	always_comb begin
		div_bad_s[0] = bad_s2;
		div_dev_s[0] = dev_s2;
		div_den_s[0] = den_s2;
		div_neg_s[0] = neg_s2;
		div_ovf_s[0] = ovf_s2;
		div_rem_s[0] = rem_s2;
		div_nq_s[0]  = nq_s2;
	end

	for (genvar k = 0; k < N_DIV; k++) begin : g_div
		logic [MAG_W-1:0] rem_n [N_LANE];
		word_t            nq_n  [N_LANE];

		for (genvar l = 0; l < N_LANE; l++) begin : g_lane
			d2q9mc_div_step u_step (
				.rem_in  (div_rem_s[k][l]),
				.nq_in   (div_nq_s[k][l]),
				.divisor (div_den_s[k]),
				.rem_out (rem_n[l]),
				.nq_out  (nq_n[l])
			);
		end

		always_ff @(posedge clk) begin
			if (ld[DIV0+k]) begin
				div_bad_s[k+1] <= div_bad_s[k];
				div_dev_s[k+1] <= div_dev_s[k];
				div_den_s[k+1] <= div_den_s[k];
				div_neg_s[k+1] <= div_neg_s[k];
				div_ovf_s[k+1] <= div_ovf_s[k];
				div_rem_s[k+1] <= rem_n;
				div_nq_s[k+1]  <= nq_n;
			end
		end
	end

	// output stage: sign, saturation, offsets
	word_t res_c [N_LANE];
	word_t res_out_q [N_LANE];
	word_t dev_out_q;
	logic  bad_out_q;

	for (genvar l = 0; l < N_LANE; l++) begin : g_post
		d2q9mc_post u_post (
			.quot   (div_nq_s[N_DIV][l]),
			.neg    (div_neg_s[N_DIV][l]),
			.ovf    (div_ovf_s[N_DIV][l]),
			.sub_cs ((l == LANE_XX) || (l == LANE_YY)),
			.cs     (sound_speed_sq_q),
			.bad    (div_bad_s[N_DIV]),
			.result (res_c[l])
		);
	end

	always_ff @(posedge clk) begin
		if (ld[N_STG-1]) begin
			res_out_q <= res_c;
			dev_out_q <= div_dev_s[N_DIV];
			bad_out_q <= div_bad_s[N_DIV];
		end
	end

	assign rho_deviation = dev_out_q;
	assign velocity_x    = res_out_q[LANE_X];
	assign velocity_y    = res_out_q[LANE_Y];
	assign moment_xx     = res_out_q[LANE_XX];
	assign moment_yy     = res_out_q[LANE_YY];
	assign moment_xy     = res_out_q[LANE_XY];
	assign bad_density   = bad_out_q;

endmodule

// ----- rtl/core/d2q9mc_checker.sv -----
// port level checks for the d2q9 moment calculator, bound to the top level
// depends on d2q9_moment_calc_top
module d2q9mc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] rho_deviation,
	input logic [31:0] velocity_x,
	input logic [31:0] velocity_y,
	input logic [31:0] moment_xx,
	input logic [31:0] moment_yy,
	input logic [31:0] moment_xy,
	input logic        bad_density
);

	// a held result item stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rho_deviation) && $stable(velocity_x))
		else $error("result item changed while stalled");

	// input back pressure only when the output is full and held
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	// bad density zeroes the moments
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_density |-> velocity_x == '0 && velocity_y == '0 &&
			moment_xx == '0 && moment_yy == '0 && moment_xy == '0)
		else $error("moments not zero on bad density");

	// a free output lets the input go
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

endmodule

bind d2q9_moment_calc_top d2q9mc_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.rho_deviation (rho_deviation),
	.velocity_x    (velocity_x),
	.velocity_y    (velocity_y),
	.moment_xx     (moment_xx),
	.moment_yy     (moment_yy),
	.moment_xy     (moment_xy),
	.bad_density   (bad_density)
);

// ----- verif/d2q9_moment_calc_top_test.sv -----
// self-checking testbench for the d2q9 moment calculator top level
// depends on d2q9mc_pkg and d2q9_moment_calc_top; predicts moments per node in-line
`timescale 1ns / 100ps
module d2q9_moment_calc_top_test;
	import d2q9mc_pkg::*;

	localparam int FRAC = 28;
	localparam longint QLIM = 64'sd1 << 40;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	typedef struct {
		logic [POP_W-1:0] p [9];
	} node_t;

	typedef struct {
		logic [Q_W-1:0] rho_dev;
		logic [Q_W-1:0] vx;
		logic [Q_W-1:0] vy;
		logic [Q_W-1:0] mxx;
		logic [Q_W-1:0] myy;
		logic [Q_W-1:0] mxy;
		logic           bad;
	} moments_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [POP_W-1:0] pop [9];
	logic             out_valid;
	logic             out_stall;
	logic [Q_W-1:0]   rho_deviation, velocity_x, velocity_y;
	logic [Q_W-1:0]   moment_xx, moment_yy, moment_xy;
	logic             bad_density;

	// model copy of the registers
	longint cs_sq;
	longint rho_ref;

	node_t    node_queue[$];
	moments_t moments_queue[$];
	int       send_idle_pct;
	int       recv_idle_pct;
	int       n_errors;

	d2q9_moment_calc_top #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pop_rest(pop[0]), .pop_east(pop[1]), .pop_north(pop[2]),
		.pop_west(pop[3]), .pop_south(pop[4]), .pop_northeast(pop[5]),
		.pop_northwest(pop[6]), .pop_southwest(pop[7]), .pop_southeast(pop[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.rho_deviation(rho_deviation), .velocity_x(velocity_x),
		.velocity_y(velocity_y), .moment_xx(moment_xx), .moment_yy(moment_yy),
		.moment_xy(moment_xy), .bad_density(bad_density)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > SMAX)
			return SMAX;
		if (v < SMIN)
			return SMIN;
		return v;
	endfunction

	// truncated fixed point quotient, magnitude capped far beyond the field range
	function automatic longint fixed_quotient(longint num, longint den);
		bit      neg;
		longint  mag, q, r;
		neg = num < 0;
		mag = neg ? -num : num;
		q = mag / den;
		r = mag % den;
		if (q > QLIM)
			q = QLIM;
		for (int i = 0; i < FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
			if (q > QLIM)
				q = QLIM;
		end
		return neg ? -q : q;
	endfunction

	function automatic moments_t predict_moments(node_t n);
		moments_t m;
		longint   f [9];
		longint   rho, nx, ny, nxx, nyy, nxy;
		rho = 0;
		for (int i = 0; i < 9; i++) begin
			f[i] = longint'($signed(n.p[i]));
			rho += f[i];
		end
		m.rho_dev = 32'(clamp32(rho - rho_ref));
		m.vx = '0;
		m.vy = '0;
		m.mxx = '0;
		m.myy = '0;
		m.mxy = '0;
		m.bad = 1'b1;
		if (rho > 0) begin
			nx  = f[1] - f[3] + f[5] - f[6] - f[7] + f[8];
			ny  = f[2] - f[4] + f[5] + f[6] - f[7] - f[8];
			nxx = f[1] + f[3] + f[5] + f[6] + f[7] + f[8];
			nyy = f[2] + f[4] + f[5] + f[6] + f[7] + f[8];
			nxy = f[5] - f[6] + f[7] - f[8];
			m.vx  = 32'(clamp32(fixed_quotient(nx, rho)));
			m.vy  = 32'(clamp32(fixed_quotient(ny, rho)));
			m.mxx = 32'(clamp32(clamp32(fixed_quotient(nxx, rho)) - cs_sq));
			m.myy = 32'(clamp32(clamp32(fixed_quotient(nyy, rho)) - cs_sq));
			m.mxy = 32'(clamp32(fixed_quotient(nxy, rho)));
			m.bad = 1'b0;
		end
		return m;
	endfunction

	// stall as seen at the last rising edge
	logic in_stall_s;
	always @(posedge clk)
		in_stall_s <= in_stall;

	// driver: one item per accepted handshake, random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			// free to move on when idle or when the last item went at the rising edge
			if (!in_valid || !in_stall_s) begin
				if (node_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					node_t n;
					n = node_queue.pop_front();
					moments_queue.push_back(predict_moments(n));
					for (int i = 0; i < 9; i++)
						pop[i] <= n.p[i];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			moments_t e;
			if (moments_queue.size() == 0) begin
				$error("result item with nothing expected");
				n_errors++;
			end else begin
				e = moments_queue.pop_front();
				if (rho_deviation !== e.rho_dev) begin
					$error("rho_deviation exp %h got %h", e.rho_dev, rho_deviation);
					n_errors++;
				end
				if (velocity_x !== e.vx) begin
					$error("velocity_x exp %h got %h", e.vx, velocity_x);
					n_errors++;
				end
				if (velocity_y !== e.vy) begin
					$error("velocity_y exp %h got %h", e.vy, velocity_y);
					n_errors++;
				end
				if (moment_xx !== e.mxx) begin
					$error("moment_xx exp %h got %h", e.mxx, moment_xx);
					n_errors++;
				end
				if (moment_yy !== e.myy) begin
					$error("moment_yy exp %h got %h", e.myy, moment_yy);
					n_errors++;
				end
				if (moment_xy !== e.mxy) begin
					$error("moment_xy exp %h got %h", e.mxy, moment_xy);
					n_errors++;
				end
				if (bad_density !== e.bad) begin
					$error("bad_density exp %b got %b", e.bad, bad_density);
					n_errors++;
				end
			end
		end
	end

	function automatic logic [POP_W-1:0] rand_pop();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $urandom_range(32'h0800_0000) - 32'h0200_0000;
		endcase
	endfunction

	// random node: mostly moderate populations, otherwise field extremes or full random words
	function automatic node_t rand_node();
		node_t n;
		int    kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 9; i++) begin
			if (kind < 7)
				n.p[i] = $urandom_range(32'h0800_0000) - 32'h0100_0000;
			else
				n.p[i] = rand_pop();
		end
		return n;
	endfunction

	task automatic push_node(logic [POP_W-1:0] v [9]);
		node_t n;
		n.p = v;
		node_queue.push_back(n);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SOUND_SPEED_SQ)
			cs_sq = val;
		else
			rho_ref = val;
	endtask

	task automatic drain();
		while (node_queue.size() > 0 || moments_queue.size() > 0 || in_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// stimulus phases
	initial begin
		logic [POP_W-1:0] v [9];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SOUND_SPEED_SQ;
		cfg_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		for (int i = 0; i < 9; i++)
			pop[i] = '0;
		cs_sq = SOUND_SPEED_SQ_RST;
		rho_ref = REFERENCE_DENSITY_RST;
		n_errors = 0;
		send_idle_pct = 34;
		recv_idle_pct = 79;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero, negative and positive density, field extremes, saturation
		for (int k = 0; k < 9; k++)
			v[k] = '0;
		push_node(v);
		for (int k = 0; k < 9; k++)
			v[k] = 32'h80000000;
		push_node(v);
		for (int k = 0; k < 9; k++)
			v[k] = 32'h7fffffff;
		push_node(v);
		for (int j = 0; j < 9; j++) begin
			for (int k = 0; k < 9; k++)
				v[k] = (k == j) ? 32'h1000_0000 : 32'h0;
			push_node(v);
		end
		for (int k = 0; k < 9; k++)
			v[k] = 32'h0;
		v[0] = 32'h0000_0001;
		v[1] = 32'h7fffffff;
		v[3] = 32'h8000_0001;
		push_node(v);
		v[2] = 32'h7fffffff;
		v[4] = 32'h80000001;
		push_node(v);
		for (int k = 0; k < 9; k++)
			v[k] = 32'hffff_ffff;
		push_node(v);
		v[0] = 32'h0000_0009;
		push_node(v);
		for (int k = 0; k < 9; k++)
			v[k] = 32'h01c7_1c72;
		push_node(v);
		drain();

		// random, sender mostly sending and receiver mostly stalled
		for (int i = 0; i < 450; i++)
			node_queue.push_back(rand_node());
		drain();

		write_reg(REG_SOUND_SPEED_SQ, 31'h7fffffff);
		write_reg(REG_REFERENCE_DENSITY, 31'h0);
		send_idle_pct = 79;
		recv_idle_pct = 34;
		for (int i = 0; i < 450; i++)
			node_queue.push_back(rand_node());
		drain();

		write_reg(REG_SOUND_SPEED_SQ, 31'h0);
		write_reg(REG_REFERENCE_DENSITY, 31'h7fffffff);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 250; i++)
			node_queue.push_back(rand_node());
		drain();

		write_reg(REG_SOUND_SPEED_SQ, 31'($urandom));
		write_reg(REG_REFERENCE_DENSITY, 31'($urandom));
		for (int i = 0; i < 250; i++)
			node_queue.push_back(rand_node());
		drain();

		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/d2q9mc_pkg.sv
rtl/core/d2q9mc_sums.sv
rtl/core/d2q9mc_div_step.sv
rtl/core/d2q9mc_post.sv
rtl/core/d2q9_moment_calc_top.sv
rtl/core/d2q9mc_checker.sv
verif/d2q9_moment_calc_top_test.sv
